>>> hdl/wad_pkg.sv
package wad_pkg;

	// default build values
	localparam int WAD_WINDOW_DEPTH  = 64;
	localparam int WAD_FRACTION_BITS = 8;

	// field widths
	localparam int KIND_W   = 1;
	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 8;
	localparam int OUT_Q_W  = 16;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// reset values of the configuration registers
	localparam logic [SAMPLE_W-1:0] CLAMP_LO_RST      = SAMPLE_W'(0);
	localparam logic [SAMPLE_W-1:0] CLAMP_HI_RST      = SAMPLE_W'(255);
	localparam logic [LEVEL_W-1:0]  INITIAL_LEVEL_RST = LEVEL_W'(0);

	// apb register map, index = paddr[3:2]
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_CLAMP_LO      = 2'd0,
		REG_CLAMP_HI      = 2'd1,
		REG_INITIAL_LEVEL = 2'd2
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 1'b0,
		KIND_REINIT = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [OUT_Q_W-1:0] average_q8;
		logic [OUT_Q_W-1:0] deviation_q8;
	} result_t;

endpackage

>>> hdl/wad_win.sv
module wad_win import wad_pkg::*; #(
	parameter int DEPTH  = WAD_WINDOW_DEPTH,
	parameter int ADDR_W = $clog2(WAD_WINDOW_DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [LEVEL_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [LEVEL_W-1:0] rdata
);

	logic [LEVEL_W-1:0] mem [DEPTH];
	logic [LEVEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/wad_div.sv
module wad_div import wad_pkg::*; #(
	parameter int DIVISOR = WAD_WINDOW_DEPTH,
	parameter int DIVN_W  = 34,
	parameter int Q_W     = LEVEL_W + WAD_FRACTION_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	output logic              done,
	output logic [Q_W-1:0]    quotient
);

	logic done_q;

	generate
		if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
			// power-of-two divisor: plain shift, registered
			localparam int SHIFT = $clog2(DIVISOR);

			logic [Q_W-1:0] quot_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					quot_q <= Q_W'(dividend >> SHIFT);
				end
			end

			assign quotient = quot_q;
		end else begin : g_recip
			// multiply by the rounded-up reciprocal 2^(DIVN_W+L)/DIVISOR,
			// CH bits of it per cycle, top chunk first
			localparam int L     = $clog2(DIVISOR);
			localparam int CH    = 16;
			localparam int NCH   = (DIVN_W + CH) / CH;
			localparam int MW    = NCH * CH;
			localparam int PW    = DIVN_W + MW;
			localparam int CNT_W = $clog2(NCH + 1);
			localparam logic [63:0] RECIP =
				((64'd1 << (DIVN_W + L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
			localparam logic [MW-1:0]    RECIP_C  = MW'(RECIP);
			localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NCH - 1);

			logic                   busy_q;
			logic [CNT_W-1:0]       cnt_q;
			logic [DIVN_W-1:0]      x_q;
			logic [MW-1:0]          recip_q;
			logic [PW-1:0]          acc_q;
			logic [DIVN_W+CH-1:0]   part;

			assign part = (DIVN_W + CH)'(x_q) * (DIVN_W + CH)'(recip_q[MW-1 -: CH]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= busy_q && (cnt_q == LAST_CNT);
					if (start && !busy_q) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						if (cnt_q == LAST_CNT) begin
							busy_q <= 1'b0;
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start && !busy_q) begin
					x_q     <= dividend;
					recip_q <= RECIP_C;
					acc_q   <= '0;
				end else if (busy_q) begin
					recip_q <= recip_q << CH;
					acc_q   <= (acc_q << CH) + PW'(part);
				end
			end

			assign quotient = acc_q[DIVN_W + L +: Q_W];
		end
	endgenerate

	assign done = done_q;

endmodule

>>> hdl/window_average_and_deviation_core.sv
// moving window average with running mean absolute deviation
//
// item channel (item_valid/item_ready/item): one transaction per raw sample
// or reinit request. result channel (result_valid/result_ready/result): one
// transaction per accepted item, in order. apb port sets the lower clamp
// (0x0), the upper clamp (0x4) and initial_level (0x8); pready is tied high.
//
// a sample takes one window read-modify-write and two divisions by
// WINDOW_DEPTH through one shared divider. with WINDOW_DEPTH a power of two
// the divider is a shift; otherwise it multiplies by a reciprocal, 16 bits
// per cycle. a reinit writes every window slot, one per cycle. one item is
// in flight at a time; item_ready is high only when the block is idle, in
// the cycle after the result is loaded, so a new sample is taken only once
// the last one is through.
//
// after reset the window memory is cleared with a pass over every slot,
// during which no item is accepted (apb writes still work).
// if the receiver stalls, one more item is taken and worked off, then the
// block holds its finished result until the output register is emptied.
module window_average_and_deviation_core import wad_pkg::*; #(
	parameter int WINDOW_DEPTH  = WAD_WINDOW_DEPTH,
	parameter int FRACTION_BITS = WAD_FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int AVG_W  = LEVEL_W + FRACTION_BITS;
	localparam int SUM_W  = $clog2(WINDOW_DEPTH * 255 + 1);
	localparam longint unsigned DEV_MAX_L =
		longint'(WINDOW_DEPTH) * (longint'(255) << FRACTION_BITS);
	localparam int DEV_W  = $clog2(DEV_MAX_L + 1);
	localparam int DIVN_W = (SUM_W + FRACTION_BITS > DEV_W) ? SUM_W + FRACTION_BITS : DEV_W;
	localparam logic [DEV_W:0]      DEV_MAX  = (DEV_W + 1)'(DEV_MAX_L);
	localparam logic [ADDR_W-1:0]   LAST_POS = ADDR_W'(WINDOW_DEPTH - 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_AVG   = 7'b0001000,
		ST_DEV   = 7'b0010000,
		ST_FILL  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [LEVEL_W-1:0]  init_q;

	// running state
	logic [ADDR_W-1:0] wptr_q;
	logic [ADDR_W-1:0] fill_addr_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DEV_W-1:0]  dev_q;
	logic [AVG_W-1:0]  avg_q;

	// result being built, then the output register
	logic [LEVEL_W-1:0] res_level_q;
	logic [AVG_W-1:0]   res_avg_q;
	logic [AVG_W-1:0]   res_dev_q;
	logic               out_valid_q;
	result_t            out_q;

	logic item_acc;
	logic result_acc;
	logic cfg_wr;
	logic out_load;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign result_acc = out_valid_q && result_ready;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign pready     = 1'b1;
	// finished result moves into a free (or freeing) output register
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || result_ready);

	// apb read back
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_CLAMP_LO:      prdata = PDATA_W'(min_q);
			REG_CLAMP_HI:      prdata = PDATA_W'(max_q);
			REG_INITIAL_LEVEL: prdata = PDATA_W'(init_q);
			default:           prdata = '0;
		endcase
	end

	// clamp, offset and saturate the raw reading
	logic [SAMPLE_W-1:0] clamped;
	logic [SAMPLE_W-1:0] offset;
	logic [LEVEL_W-1:0]  new_level;

	always_comb begin
		priority if (item.sample < min_q) begin
			clamped = min_q;
		end else if (item.sample > max_q) begin
			clamped = max_q;
		end else begin
			clamped = item.sample;
		end
		offset = clamped - min_q;
		// crossed bounds: clamped is the upper bound, below the lower one
		priority if (clamped < min_q) begin
			new_level = '0;
		end else if (offset > SAMPLE_W'(LEVEL_MAX)) begin
			new_level = LEVEL_MAX;
		end else begin
			new_level = offset[LEVEL_W-1:0];
		end
	end

	// window memory
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [LEVEL_W-1:0] mem_wdata;
	logic [LEVEL_W-1:0] mem_rdata;

	assign mem_we    = (state_q == ST_READ) || (state_q == ST_CLEAR) || (state_q == ST_FILL);
	assign mem_waddr = (state_q == ST_READ) ? wptr_q : fill_addr_q;
	always_comb begin
		unique case (state_q)
			ST_READ: mem_wdata = res_level_q;
			ST_FILL: mem_wdata = init_q;
			default: mem_wdata = '0;
		endcase
	end

	wad_win #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (ADDR_W)
	) u_win (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (item_acc),
		.raddr (wptr_q),
		.rdata (mem_rdata)
	);

	// departing level against the previous average
	logic [AVG_W-1:0] old_q8;
	logic [AVG_W-1:0] term_old;
	logic [DEV_W-1:0] dev_after_old;
	logic [SUM_W-1:0] sum_new;

	assign old_q8   = AVG_W'(mem_rdata) << FRACTION_BITS;
	assign term_old = (old_q8 > avg_q) ? (old_q8 - avg_q) : (avg_q - old_q8);
	assign dev_after_old = (dev_q > DEV_W'(term_old)) ? (dev_q - DEV_W'(term_old)) : '0;
	assign sum_new  = sum_q - SUM_W'(mem_rdata) + SUM_W'(res_level_q);

	// arriving level against the new average
	logic               div_start;
	logic [DIVN_W-1:0]  div_dividend;
	logic               div_done;
	logic [AVG_W-1:0]   div_quot;
	logic [AVG_W-1:0]   new_q8;
	logic [AVG_W-1:0]   term_new;
	logic [DEV_W:0]     dev_sum;
	logic [DEV_W-1:0]   dev_new;

	assign new_q8   = AVG_W'(res_level_q) << FRACTION_BITS;
	assign term_new = (new_q8 > div_quot) ? (new_q8 - div_quot) : (div_quot - new_q8);
	assign dev_sum  = (DEV_W + 1)'(dev_q) + (DEV_W + 1)'(term_new);
	assign dev_new  = (dev_sum > DEV_MAX) ? DEV_MAX[DEV_W-1:0] : dev_sum[DEV_W-1:0];

	// one divider: first the new average, then the mean deviation
	assign div_start    = (state_q == ST_READ) || ((state_q == ST_AVG) && div_done);
	assign div_dividend = (state_q == ST_READ) ? (DIVN_W'(sum_new) << FRACTION_BITS)
	                                           : DIVN_W'(dev_new);

	wad_div #(
		.DIVISOR (WINDOW_DEPTH),
		.DIVN_W  (DIVN_W),
		.Q_W     (AVG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			min_q       <= CLAMP_LO_RST;
			max_q       <= CLAMP_HI_RST;
			init_q      <= INITIAL_LEVEL_RST;
			wptr_q      <= '0;
			fill_addr_q <= '0;
			sum_q       <= '0;
			dev_q       <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_CLAMP_LO:      min_q  <= pwdata[SAMPLE_W-1:0];
					REG_CLAMP_HI:      max_q  <= pwdata[SAMPLE_W-1:0];
					REG_INITIAL_LEVEL: init_q <= pwdata[LEVEL_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_acc) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (fill_addr_q == LAST_POS) begin
						fill_addr_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						fill_addr_q <= fill_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (item_acc) begin
						if (item.kind == KIND_REINIT) begin
							fill_addr_q <= '0;
							state_q     <= ST_FILL;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q   <= sum_new;
					dev_q   <= dev_after_old;
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (div_done) begin
						avg_q   <= div_quot;
						dev_q   <= dev_new;
						state_q <= ST_DEV;
					end
				end
				ST_DEV: begin
					if (div_done) begin
						wptr_q  <= (wptr_q == LAST_POS) ? '0 : wptr_q + 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_FILL: begin
					if (fill_addr_q == LAST_POS) begin
						fill_addr_q <= '0;
						sum_q       <= SUM_W'(WINDOW_DEPTH) * SUM_W'(init_q);
						dev_q       <= '0;
						avg_q       <= AVG_W'(init_q) << FRACTION_BITS;
						wptr_q      <= '0;
						state_q     <= ST_OUT;
					end else begin
						fill_addr_q <= fill_addr_q + 1'b1;
					end
				end
				ST_OUT: begin
					// wait for a free output register
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_level_q <= (item.kind == KIND_REINIT) ? init_q : new_level;
		end
		if ((state_q == ST_AVG) && div_done) begin
			res_avg_q <= div_quot;
		end
		if ((state_q == ST_DEV) && div_done) begin
			res_dev_q <= div_quot;
		end
		if ((state_q == ST_FILL) && (fill_addr_q == LAST_POS)) begin
			res_avg_q <= AVG_W'(init_q) << FRACTION_BITS;
			res_dev_q <= '0;
		end
		if (out_load) begin
			out_q.level        <= res_level_q;
			out_q.average_q8   <= OUT_Q_W'(res_avg_q);
			out_q.deviation_q8 <= OUT_Q_W'(res_dev_q);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
